### sv/rgbpb_pkg.sv
// ----------------------------------------------------------------------------
// rgbpb_pkg
// Shared constants and types for the RGB palette builder.
// ----------------------------------------------------------------------------
package rgbpb_pkg;

    localparam int PALETTE_SIZE = 256;
    localparam int IDX_W        = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
    localparam int CH_W         = 8;
    localparam int COLOR_W      = 3 * CH_W;
    localparam int INDEX_W      = 8;
    localparam int COUNT_W      = 9;

    typedef struct packed {
        logic               act;
        logic [COLOR_W-1:0] rgb;
    } t_tok;

    typedef struct packed {
        logic clear;
        logic en;
    } t_chain_ctl;

    typedef struct packed {
        logic hit;
        logic empty;
        logic full_miss;
    } t_scan_stat;

endpackage

### sv/rgbpb_cell.sv
// ----------------------------------------------------------------------------
// rgbpb_cell
// One palette slot: stored color, valid bit and the search token in transit.
// ----------------------------------------------------------------------------
module rgbpb_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rgbpb_pkg::t_chain_ctl i_ctl,
    input  rgbpb_pkg::t_tok       i_tok,
    output rgbpb_pkg::t_tok       o_tok,
    output logic                  o_hit,
    output logic                  o_empty
);

    logic                          r_act;
    logic [rgbpb_pkg::COLOR_W-1:0] r_rgb;
    logic                          r_valid;
    logic [rgbpb_pkg::COLOR_W-1:0] r_color;

    assign o_hit     = r_act & r_valid & (r_color == r_rgb);
    assign o_empty   = r_act & ~r_valid;
    assign o_tok.act = r_act & r_valid & ~o_hit;
    assign o_tok.rgb = r_rgb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (i_ctl.en) begin
                r_act <= i_tok.act;
            end
            if (i_ctl.clear) begin
                r_valid <= 1'b0;
            end else if (i_ctl.en && o_empty) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_rgb <= i_tok.rgb;
        end
        if (i_ctl.en && o_empty) begin
            r_color <= r_rgb;
        end
    end

endmodule

### sv/rgbpb_chain.sv
// ----------------------------------------------------------------------------
// rgbpb_chain
// Row of palette cells; the search token steps one cell per cycle while the chain is enabled.
// ----------------------------------------------------------------------------
module rgbpb_chain (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rgbpb_pkg::t_chain_ctl i_ctl,
    input  rgbpb_pkg::t_tok       i_tok,
    output rgbpb_pkg::t_scan_stat o_stat
);

    rgbpb_pkg::t_tok                     w_tok [rgbpb_pkg::PALETTE_SIZE+1];
    logic [rgbpb_pkg::PALETTE_SIZE-1:0] w_hit;
    logic [rgbpb_pkg::PALETTE_SIZE-1:0] w_empty;

    assign w_tok[0] = i_tok;

    for (genvar g = 0; g < rgbpb_pkg::PALETTE_SIZE; g++) begin : g_cell
        rgbpb_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (i_ctl),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1]),
            .o_hit   (w_hit[g]),
            .o_empty (w_empty[g])
        );
    end

    assign o_stat.hit       = |w_hit;
    assign o_stat.empty     = |w_empty;
    assign o_stat.full_miss = w_tok[rgbpb_pkg::PALETTE_SIZE].act;

endmodule

### sv/rgb_palette_builder.sv
// ----------------------------------------------------------------------------
// rgb_palette_builder
// Exact palette builder: looks up each pixel, adds new colors in order.
//
// Channel   Dir  tdata (low bit up)                 tuser (low bit up)
// s_axis    in   red, green, blue                   start_frame
// m_axis    out  color_index, color_count (+pad)    added_color, palette_overflow
//
// A pixel's scan ends at the slot where it hits, at the first empty slot
// on a miss, or past the last slot when the palette is full.
// The search token walks the cell chain one slot per cycle while it is not frozen.
// Reset empties the palette at once (valid bits are flip-flops).
// A waiting result does not block input; during a scan, a result register
// that is still full and not taken freezes the chain until it drains.
// ----------------------------------------------------------------------------
module rgb_palette_builder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
    input  logic        i_s_axis_tuser,   // start_frame
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // color_index[7:0], color_count[16:8], zero
    output logic [1:0]  o_m_axis_tuser    // added_color[0], palette_overflow[1]
);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    t_state                          r_state;
    logic [rgbpb_pkg::IDX_W-1:0]     r_pos;
    logic [rgbpb_pkg::COUNT_W-1:0]   r_count;
    logic                            r_ovf;
    logic                            r_out_valid;
    logic [rgbpb_pkg::INDEX_W-1:0]   r_out_index;
    logic                            r_out_added;
    logic                            r_out_ovf;
    logic [rgbpb_pkg::COUNT_W-1:0]   r_out_count;

    logic [rgbpb_pkg::COUNT_W-1:0]   n_count;
    logic                            n_ovf;
    logic [rgbpb_pkg::INDEX_W-1:0]   n_index;
    logic                            n_added;
    logic [rgbpb_pkg::COUNT_W-1:0]   w_count_inc;

    logic                            w_in_acc;
    logic                            w_done;
    logic                            w_out_load;
    rgbpb_pkg::t_chain_ctl           w_ctl;
    rgbpb_pkg::t_tok                 w_tok;
    rgbpb_pkg::t_scan_stat           w_stat;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc        = i_s_axis_tvalid & o_s_axis_tready;

    assign w_ctl.clear = w_in_acc & i_s_axis_tuser;
    assign w_ctl.en    = (r_state == ST_IDLE) | ~(r_out_valid & ~i_m_axis_tready);
    assign w_tok.act   = w_in_acc;
    assign w_tok.rgb   = i_s_axis_tdata;

    rgbpb_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_tok   (w_tok),
        .o_stat  (w_stat)
    );

    assign w_done      = w_stat.hit | w_stat.empty | w_stat.full_miss;
    assign w_out_load  = (r_state == ST_SCAN) & w_ctl.en & w_done;
    assign w_count_inc = r_count + rgbpb_pkg::COUNT_W'(1);

    always_comb begin
        n_index = rgbpb_pkg::INDEX_W'(r_pos);
        n_added = 1'b0;
        n_count = r_count;
        n_ovf   = r_ovf;
        if (w_stat.empty) begin
            n_added = 1'b1;
            n_count = w_count_inc;
            n_ovf   = (w_count_inc >= rgbpb_pkg::COUNT_W'(rgbpb_pkg::PALETTE_SIZE));
        end else if (!w_stat.hit) begin
            n_index = '0;
            n_ovf   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        if (i_s_axis_tuser) begin
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                        end
                        r_pos   <= '0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (w_ctl.en) begin
                        if (w_done) begin
                            r_count     <= n_count;
                            r_ovf       <= n_ovf;
                            r_out_index <= n_index;
                            r_out_added <= n_added;
                            r_out_ovf   <= n_ovf;
                            r_out_count <= n_count;
                            r_state     <= ST_IDLE;
                        end else begin
                            r_pos <= r_pos + rgbpb_pkg::IDX_W'(1);
                        end
                    end
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out_count, r_out_index};
    assign o_m_axis_tuser  = {r_out_ovf, r_out_added};

endmodule

### sv/rgbpb_checker.sv
// ----------------------------------------------------------------------------
// rgbpb_checker
// Port-level checks for the palette builder, bound to the top level.
// ----------------------------------------------------------------------------
module rgbpb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        i_s_tready,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] i_m_tdata,
    input logic [1:0]  i_m_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=>
            i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready |=> !i_s_tready)
        else $error("second pixel taken during a scan");

    a_added_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser[0] |->
            i_m_tdata[16:8] == ({1'b0, i_m_tdata[7:0]} + 9'd1))
        else $error("new color not placed in next free slot");

    a_ovf_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |->
            (i_m_tdata[16:8] <= rgbpb_pkg::COUNT_W'(rgbpb_pkg::PALETTE_SIZE)) &&
            (i_m_tuser[1] ==
                (i_m_tdata[16:8] == rgbpb_pkg::COUNT_W'(rgbpb_pkg::PALETTE_SIZE))))
        else $error("overflow flag disagrees with color count");

endmodule

bind rgb_palette_builder rgbpb_checker u_rgbpb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_axis_tvalid),
    .i_s_tready (o_s_axis_tready),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tuser  (o_m_axis_tuser)
);

### bench/rgb_palette_builder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_palette_builder_tb
// Streams RGB pixels into the palette builder with random gaps on both sides.
// A scoreboard keeps its own palette per frame, predicts index, count, added
// and overflow for every pixel transfer, and checks each result transfer in
// order. Covers frame restarts, stale colors, full palettes and overflow.
// ----------------------------------------------------------------------------
module rgb_palette_builder_tb;

    localparam int WATCHDOG_LIMIT = 8 * (rgbpb_pkg::PALETTE_SIZE + 30);

    typedef struct packed {
        logic [rgbpb_pkg::INDEX_W-1:0] index;
        logic [rgbpb_pkg::COUNT_W-1:0] count;
        logic                          added;
        logic                          overflow;
    } t_lookup;

    class palette_scoreboard;
        logic [rgbpb_pkg::COLOR_W-1:0] pal_color [rgbpb_pkg::PALETTE_SIZE];
        bit                            pal_valid [rgbpb_pkg::PALETTE_SIZE];
        int                            color_total;
        bit                            overflow_flag;
        int                            errors;
        t_lookup                       pending_lookups [$];

        function new();
            errors = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            foreach (pal_valid[s]) pal_valid[s] = 1'b0;
            color_total   = 0;
            overflow_flag = 1'b0;
        endfunction

        function int pending();
            return pending_lookups.size();
        endfunction

        function void note_pixel(bit start_frame, logic [rgbpb_pkg::COLOR_W-1:0] rgb);
            t_lookup want;
            bit      hit;
            int      s;
            if (start_frame) clear_frame();
            hit        = 1'b0;
            want.index = '0;
            want.added = 1'b0;
            for (s = 0; s < rgbpb_pkg::PALETTE_SIZE && !hit; s++) begin
                if (pal_valid[s] && pal_color[s] == rgb) begin
                    hit        = 1'b1;
                    want.index = s[rgbpb_pkg::INDEX_W-1:0];
                end
            end
            if (!hit) begin
                if (!overflow_flag && color_total < rgbpb_pkg::PALETTE_SIZE) begin
                    want.index             = color_total[rgbpb_pkg::INDEX_W-1:0];
                    pal_color[color_total] = rgb;
                    pal_valid[color_total] = 1'b1;
                    color_total++;
                    want.added = 1'b1;
                    if (color_total >= rgbpb_pkg::PALETTE_SIZE) overflow_flag = 1'b1;
                end else begin
                    overflow_flag = 1'b1;
                end
            end
            want.overflow = overflow_flag;
            want.count    = color_total[rgbpb_pkg::COUNT_W-1:0];
            pending_lookups.push_back(want);
        endfunction

        task report(string msg);
            errors++;
            $display("%0t ERROR: %s", $realtime, msg);
        endtask

        task check_field(string name, logic [rgbpb_pkg::COUNT_W-1:0] got,
                         logic [rgbpb_pkg::COUNT_W-1:0] want);
            if (got !== want) report($sformatf("%s got %0d want %0d", name, got, want));
        endtask

        task check_result(logic [23:0] data, logic [1:0] user);
            t_lookup want;
            if (pending_lookups.size() == 0) begin
                report("result transfer with no pixel pending");
                return;
            end
            want = pending_lookups.pop_front();
            check_field("color_index", rgbpb_pkg::COUNT_W'(data[7:0]),
                        rgbpb_pkg::COUNT_W'(want.index));
            check_field("color_count", data[16:8], want.count);
            check_field("added_color", rgbpb_pkg::COUNT_W'(user[0]),
                        rgbpb_pkg::COUNT_W'(want.added));
            check_field("palette_overflow", rgbpb_pkg::COUNT_W'(user[1]),
                        rgbpb_pkg::COUNT_W'(want.overflow));
        endtask
    endclass

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata  = '0;  // red, green, blue
    logic        i_s_axis_tuser  = 1'b0; // start_frame
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [23:0] o_m_axis_tdata;        // color_index, color_count, zero pad
    logic [1:0]  o_m_axis_tuser;        // added_color, palette_overflow

    palette_scoreboard sb;
    bit                calm = 1'b0;
    int                sent = 0;
    int                stall_cycles = 0;

    rgb_palette_builder u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic send_pixel(input bit sf, input logic [rgbpb_pkg::COLOR_W-1:0] rgb);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= sf;
        i_s_axis_tdata  <= {rgb[7:0], rgb[15:8], rgb[23:16]};
        do @(posedge i_clk);
        while (!(i_s_axis_tvalid === 1'b1 && o_s_axis_tready === 1'b1));
        sb.note_pixel(sf, rgb);
        sent++;
    endtask

    // short frames over a small color pool, mostly with a frame start
    task automatic random_frame();
        logic [rgbpb_pkg::COLOR_W-1:0] pool [8];
        int                            n_pool;
        int                            len;
        int                            k;
        bit                            sf;
        calm   = ($urandom_range(0, 4) == 0);
        n_pool = $urandom_range(1, 8);
        for (k = 0; k < n_pool; k++) pool[k] = rgbpb_pkg::COLOR_W'($urandom);
        len = $urandom_range(1, 24);
        for (k = 0; k < len; k++) begin
            sf = (k == 0) && ($urandom_range(0, 7) != 0);
            if ($urandom_range(0, 9) < 7) send_pixel(sf, pool[$urandom_range(0, n_pool - 1)]);
            else send_pixel(sf, rgbpb_pkg::COLOR_W'($urandom));
        end
    endtask

    // fill every slot, then push new colors and hits past overflow
    task automatic fill_palette();
        logic [15:0] tag;
        int          k;
        int          j;
        tag  = 16'($urandom);
        calm = ($urandom_range(0, 1) == 1);
        for (k = 0; k < rgbpb_pkg::PALETTE_SIZE; k++) begin
            send_pixel(k == 0, {tag, k[7:0]});
            if ($urandom_range(0, 5) == 0) begin
                j = $urandom_range(0, k);
                send_pixel(1'b0, {tag, j[7:0]});
            end
        end
        for (k = 0; k < 12; k++) begin
            if (k[0]) begin
                send_pixel(1'b0, {~tag, k[7:0]});
            end else begin
                j = (k == 0) ? rgbpb_pkg::PALETTE_SIZE - 1
                             : $urandom_range(0, rgbpb_pkg::PALETTE_SIZE - 1);
                send_pixel(1'b0, {tag, j[7:0]});
            end
        end
    endtask

    initial begin
        wait (i_rst_n === 1'b1);
        forever begin
            int stall;
            stall = calm ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk);
            while (!(o_m_axis_tvalid === 1'b1 && i_m_axis_tready === 1'b1));
            sb.check_result(o_m_axis_tdata, o_m_axis_tuser);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("rgb_palette_builder_tb: done, errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int round;
        int target;
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // palette is empty out of reset, no frame start needed
        send_pixel(1'b0, 24'h000000);
        send_pixel(1'b0, 24'hFFFFFF);
        send_pixel(1'b0, 24'h000000);
        send_pixel(1'b0, 24'hFFFFFF);
        // frame start: pixel lands in slot 0, old color is stale
        send_pixel(1'b1, 24'hFFFFFF);
        send_pixel(1'b0, 24'h000000);
        send_pixel(1'b1, 24'hFFFFFF);
        send_pixel(1'b1, 24'hFFFFFF);
        send_pixel(1'b0, 24'hFF0000);
        send_pixel(1'b0, 24'h00FF00);
        send_pixel(1'b0, 24'h0000FF);
        send_pixel(1'b0, 24'h00FF00);
        send_pixel(1'b0, 24'h800001);
        send_pixel(1'b0, 24'h0000FF);
        calm = 1'b1;
        send_pixel(1'b1, 24'h123456);
        send_pixel(1'b0, 24'h123456);
        send_pixel(1'b0, 24'h654321);
        send_pixel(1'b0, 24'h7F7F7F);
        send_pixel(1'b0, 24'h123456);

        for (round = 0; round < 2; round++) begin
            target = sent + 40;
            while (sent < target) random_frame();
            if (round == 0) fill_palette();
        end
        i_s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (rgbpb_pkg::PALETTE_SIZE + 4) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("rgb_palette_builder_tb: done, clean");
        end else begin
            $display("rgb_palette_builder_tb: done, errors");
        end
        $finish;
    end

endmodule
